### rtl/wpc_pkg.sv
// ----------------------------------------------------------------------------
// wpc_pkg
// Shared types, codes and defaults of the window peak counter.
// ----------------------------------------------------------------------------
package wpc_pkg;

    localparam int MAX_WINDOW_DEF  = 1024;
    localparam int MAX_RUN_DEF     = 65536;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int WLEN_BITS   = 11;
    localparam int COUNT_BITS  = 11;
    localparam int PEAKS_BITS  = 10;
    localparam int START_BITS  = 17;
    localparam int STATUS_BITS = 2;

    localparam logic [WLEN_BITS-1:0]  WLEN_RESET = 11'd3;
    localparam logic [WLEN_BITS-1:0]  WLEN_MIN   = 11'd3;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 11'd2047;
    localparam logic [PEAKS_BITS-1:0] PEAKS_MAX  = 10'd1023;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SHORT    = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [PEAKS_BITS-1:0] best_peaks;
        logic [START_BITS-1:0] best_start;
        status_t               status;
    } wpc_result_t;

    typedef struct packed {
        logic shift;
        logic flag;
    } wpc_chain_ctl_t;

endpackage

### rtl/wpc_if.sv
// ----------------------------------------------------------------------------
// wpc_sample_if / wpc_result_if
// Valid/ready channels for sample words and result words.
// ----------------------------------------------------------------------------
interface wpc_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface wpc_result_if;
    logic        valid;
    logic        ready;
    logic [9:0]  best_peaks;
    logic [16:0] best_start;
    logic [1:0]  status;

    modport source (output valid, output best_peaks, output best_start, output status,
                    input ready);
    modport sink   (input valid, input best_peaks, input best_start, input status,
                    output ready);
endinterface

### rtl/wpc_cell.sv
// ----------------------------------------------------------------------------
// wpc_cell
// One stage of the peak flag delay chain: load the new flag or take the
// neighbor's flag on each shift.
// ----------------------------------------------------------------------------
module wpc_cell
    import wpc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  wpc_chain_ctl_t ctl,
    input  logic           inject,
    input  logic           from_next,
    output logic           flag
);

    logic flag_reg;
    logic flag_next;

    always_comb
    begin
        flag_next = flag_reg;
        if (ctl.shift)
        begin
            flag_next = inject ? ctl.flag : from_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

    assign flag = flag_reg;

endmodule

### rtl/wpc_flag_chain.sv
// ----------------------------------------------------------------------------
// wpc_flag_chain
// Row of flag cells; a flag loaded at the cell picked by the window length
// leaves the head of the row after window_length - 2 shifts.
// ----------------------------------------------------------------------------
module wpc_flag_chain
    import wpc_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int KW         = $clog2(MAX_WINDOW + 1)
)(
    input  logic           clk,
    input  logic           rst_n,
    input  wpc_chain_ctl_t ctl,
    input  logic [KW-1:0]  inject_idx,
    output logic           old_flag
);

    localparam int NCELLS = MAX_WINDOW - 2;

    logic [NCELLS:0] link;

    assign link[NCELLS] = 1'b0;

    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        wpc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .inject    (inject_idx == KW'(i)),
            .from_next (link[i+1]),
            .flag      (link[i])
        );
    end

    assign old_flag = link[0];

endmodule

### rtl/window_peak_count_max_core.sv
// ----------------------------------------------------------------------------
// window_peak_count_max_core
// Sliding-window interior peak counter with best-window tracking.
// ----------------------------------------------------------------------------
// One sample word is taken every clock cycle while input is not stalled; the
// running window count is updated by one compare-and-count step per sample,
// and the flag of the peak leaving the window comes out of a row of
// MAX_WINDOW - 2 one-bit cells, so no memory port limits the rate. The
// result word of a run is registered into an output register backed by one
// skid stage; input stalls only while both hold results. There is no
// clearing pass after reset. Write window_length only between runs.
// ----------------------------------------------------------------------------
module window_peak_count_max_core
    import wpc_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int MAX_RUN     = MAX_RUN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [WLEN_BITS-1:0] cfg_wdata,
    wpc_sample_if.sink           samples,
    wpc_result_if.source         results
);

    localparam int KW = $clog2(MAX_WINDOW + 1);
    localparam int PW = $clog2(MAX_RUN + 1);
    localparam int CW = ((PW > KW) ? PW : KW) + 1;

    logic [WLEN_BITS-1:0]   wlen_reg;
    logic [SAMPLE_BITS-1:0] prev_reg,  prev_next;
    logic [SAMPLE_BITS-1:0] prev2_reg, prev2_next;
    logic [PW-1:0]          pos_reg,   pos_next;
    logic [COUNT_BITS-1:0]  wc_reg,    wc_next;
    logic [COUNT_BITS-1:0]  best_reg,  best_next;
    logic [PW-1:0]          bpos_reg,  bpos_next;
    logic                   ovf_reg,   ovf_next;

    wpc_result_t out_reg,  skid_reg;
    logic        out_valid_reg, skid_valid_reg;

    logic [KW-1:0]         k_eff;
    logic [CW-1:0]         k_x;
    logic [CW-1:0]         e_x;
    logic [PW-1:0]         e;
    logic                  fire;
    logic                  proc;
    logic                  pk;
    logic                  has_old;
    logic                  old_flag;
    logic [COUNT_BITS-1:0] wc_inc;
    logic [COUNT_BITS-1:0] wc_dec;
    wpc_chain_ctl_t        chain_ctl;
    wpc_result_t           res;
    logic [PW+START_BITS-1:0] start_ext;

    // saturate the window length into its legal range
    always_comb
    begin
        if (wlen_reg < WLEN_MIN)
        begin
            k_eff = KW'(WLEN_MIN);
        end
        else if (32'(wlen_reg) > MAX_WINDOW)
        begin
            k_eff = KW'(MAX_WINDOW);
        end
        else
        begin
            k_eff = KW'(wlen_reg);
        end
    end

    assign samples.ready = !skid_valid_reg;
    assign fire          = samples.valid && samples.ready;
    assign proc          = fire && (pos_reg < PW'(MAX_RUN));

    assign e       = pos_reg + PW'(1);
    assign e_x     = CW'(e);
    assign k_x     = CW'(k_eff);
    assign has_old = e_x > k_x;
    assign pk      = (e_x >= CW'(3)) && (prev_reg > prev2_reg) && (prev_reg > samples.sample);

    assign chain_ctl.shift = proc;
    assign chain_ctl.flag  = pk;

    wpc_flag_chain #(
        .MAX_WINDOW (MAX_WINDOW),
        .KW         (KW)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (chain_ctl),
        .inject_idx (k_eff - KW'(3)),
        .old_flag   (old_flag)
    );

    always_comb
    begin
        wc_inc = (pk && (wc_reg != COUNT_MAX)) ? wc_reg + COUNT_BITS'(1) : wc_reg;
        wc_dec = (has_old && old_flag && (wc_inc != '0)) ? wc_inc - COUNT_BITS'(1) : wc_inc;

        prev_next  = prev_reg;
        prev2_next = prev2_reg;
        pos_next   = pos_reg;
        wc_next    = wc_reg;
        best_next  = best_reg;
        bpos_next  = bpos_reg;
        ovf_next   = ovf_reg;

        if (proc)
        begin
            wc_next    = wc_dec;
            prev2_next = prev_reg;
            prev_next  = samples.sample;
            pos_next   = e;
            if ((e_x >= k_x) && (wc_dec > best_reg))
            begin
                best_next = wc_dec;
                bpos_next = PW'(e_x - k_x + CW'(1));
            end
        end
        else if (fire)
        begin
            ovf_next = 1'b1;
        end

        // build the result from the updated run state
        start_ext      = {{START_BITS{1'b0}}, bpos_next};
        res.best_peaks = (best_next > COUNT_BITS'(PEAKS_MAX)) ? PEAKS_MAX
                                                              : best_next[PEAKS_BITS-1:0];
        res.best_start = start_ext[START_BITS-1:0];
        res.status     = STATUS_OK;
        if (CW'(pos_next) < k_x)
        begin
            res.best_peaks = '0;
            res.best_start = START_BITS'(1);
            res.status     = STATUS_SHORT;
        end
        if (ovf_next)
        begin
            res.status = STATUS_OVERFLOW;
        end

        // clear the run on its last word
        if (fire && samples.last)
        begin
            prev_next  = '0;
            prev2_next = '0;
            pos_next   = '0;
            wc_next    = '0;
            best_next  = '0;
            bpos_next  = PW'(1);
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg  <= WLEN_RESET;
            prev_reg  <= '0;
            prev2_reg <= '0;
            pos_reg   <= '0;
            wc_reg    <= '0;
            best_reg  <= '0;
            bpos_reg  <= PW'(1);
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                wlen_reg <= cfg_wdata;
            end
            prev_reg  <= prev_next;
            prev2_reg <= prev2_next;
            pos_reg   <= pos_next;
            wc_reg    <= wc_next;
            best_reg  <= best_next;
            bpos_reg  <= bpos_next;
            ovf_reg   <= ovf_next;
        end
    end

    // output register with one skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || results.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= fire && samples.last;
            end
        end
        else if (fire && samples.last)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || results.ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (fire && samples.last)
        begin
            skid_reg <= res;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.best_peaks = out_reg.best_peaks;
    assign results.best_start = out_reg.best_start;
    assign results.status     = out_reg.status;

endmodule
